### hw/rtl/iphfe_pkg.sv
`default_nettype none
package iphfe_pkg;

	// byte counter width and the working width for length arithmetic
	localparam int COUNT_BITS = 16;
	localparam int LEN_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [6:0] MIN_V4_LEN = 7'd20;
	localparam logic [6:0] MIN_V6_LEN = 7'd40;
	localparam logic [6:0] PORT_BYTES = 7'd4;
	localparam logic [6:0] TCP_HDR_LEN = 7'd20;
	localparam logic [6:0] UDP_HDR_LEN = 7'd8;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [3:0] VER_V4 = 4'd4;
	localparam logic [3:0] VER_V6 = 4'd6;

	typedef logic [COUNT_BITS-1:0] count_t;

	// per-packet capture state
	typedef struct packed {
		count_t        byte_count;
		logic [3:0]    ver_nibble;
		logic [5:0]    header_bytes;
		logic [7:0]    proto_byte;
		logic [127:0]  source_address;
		logic [127:0]  dest_address;
		logic [31:0]   port_bytes;
	} parse_state_t;

	// one packet summary
	typedef struct packed {
		logic          status;
		logic [3:0]    version;
		logic [7:0]    protocol;
		logic [63:0]   src_addr_high;
		logic [63:0]   src_addr_low;
		logic [63:0]   dst_addr_high;
		logic [63:0]   dst_addr_low;
		logic [15:0]   src_port;
		logic [15:0]   dst_port;
		logic [6:0]    payload_offset;
		logic [15:0]   payload_length;
	} parse_result_t;

endpackage
`default_nettype wire

### hw/rtl/iphfe_parse.sv
`default_nettype none
module iphfe_parse (
	input  wire iphfe_pkg::parse_state_t  cur,
	input  wire logic [7:0]               data_byte,
	output iphfe_pkg::parse_state_t       nxt,
	output iphfe_pkg::parse_result_t      res
);
	import iphfe_pkg::*;

	count_t           idx;
	logic [6:0]       tstart;
	logic [6:0]       tend;
	logic             known;
	logic             in_window;

	count_t           len;
	logic [LEN_W-1:0] len_w;
	logic [6:0]       hdr;
	logic             ok;
	logic             ports;
	logic [6:0]       off;
	logic [LEN_W-1:0] diff;

	// capture of the current byte by its offset in the packet
	always_comb begin
		idx    = cur.byte_count;
		nxt    = cur;
		tstart = '0;
		known  = 1'b0;
		if (idx == '0) begin
			nxt.ver_nibble   = data_byte[7:4];
			nxt.header_bytes = {data_byte[3:0], 2'b00};
		end else if (cur.ver_nibble == VER_V4) begin
			known  = 1'b1;
			tstart = {1'b0, cur.header_bytes};
			if (idx == COUNT_BITS'(9))
				nxt.proto_byte = data_byte;
			else if (idx >= COUNT_BITS'(12) && idx <= COUNT_BITS'(15))
				nxt.source_address = {cur.source_address[119:0], data_byte};
			else if (idx >= COUNT_BITS'(16) && idx <= COUNT_BITS'(19))
				nxt.dest_address = {cur.dest_address[119:0], data_byte};
		end else if (cur.ver_nibble == VER_V6) begin
			known  = 1'b1;
			tstart = MIN_V6_LEN;
			if (idx == COUNT_BITS'(6))
				nxt.proto_byte = data_byte;
			else if (idx >= COUNT_BITS'(8) && idx <= COUNT_BITS'(23))
				nxt.source_address = {cur.source_address[119:0], data_byte};
			else if (idx >= COUNT_BITS'(24) && idx <= COUNT_BITS'(39))
				nxt.dest_address = {cur.dest_address[119:0], data_byte};
		end
		tend      = tstart + PORT_BYTES;
		in_window = (idx >= COUNT_BITS'(tstart)) && (idx < COUNT_BITS'(tend));
		if (known && in_window)
			nxt.port_bytes = {cur.port_bytes[23:0], data_byte};
		// saturating byte count
		if (cur.byte_count != COUNT_MAX)
			nxt.byte_count = cur.byte_count + count_t'(1);
	end

	// packet summary from the state after this byte
	always_comb begin
		len   = nxt.byte_count;
		len_w = LEN_W'(len);
		hdr   = '0;
		ok    = 1'b0;
		if (nxt.ver_nibble == VER_V4) begin
			hdr = {1'b0, nxt.header_bytes};
			ok  = (hdr >= MIN_V4_LEN) && (LEN_W'(hdr) <= len_w);
		end else if (nxt.ver_nibble == VER_V6) begin
			hdr = MIN_V6_LEN;
			ok  = len_w >= LEN_W'(MIN_V6_LEN);
		end
		ports = ((nxt.proto_byte == PROTO_TCP) || (nxt.proto_byte == PROTO_UDP)) &&
			(len_w >= LEN_W'(hdr + PORT_BYTES));
		off   = hdr + ((nxt.proto_byte == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
		diff  = (len_w > LEN_W'(off)) ? (len_w - LEN_W'(off)) : '0;

		res = '0;
		if (len_w < LEN_W'(MIN_V4_LEN)) begin
			res.status = 1'b1;
		end else if (!ok) begin
			res.status  = 1'b1;
			res.version = nxt.ver_nibble;
		end else begin
			res.version        = nxt.ver_nibble;
			res.protocol       = nxt.proto_byte;
			res.src_addr_high  = nxt.source_address[127:64];
			res.src_addr_low   = nxt.source_address[63:0];
			res.dst_addr_high  = nxt.dest_address[127:64];
			res.dst_addr_low   = nxt.dest_address[63:0];
			if (ports) begin
				res.src_port = nxt.port_bytes[31:16];
				res.dst_port = nxt.port_bytes[15:0];
			end
			res.payload_offset = off;
			res.payload_length = (diff > LEN_W'(16'hFFFF)) ? 16'hFFFF : diff[15:0];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ip_header_field_extractor_unit.sv
`default_nettype none
// IP header field extractor.
// Input channel: one packet byte per transfer (data_byte, with last on the
// final byte), valid/ready handshake. Output channel: one summary per packet
// (status, version, protocol, addresses, ports, payload offset and length),
// valid/ready handshake, presented after the transfer of the last byte.
// Throughput: one byte per cycle, sustained across packet boundaries while the output slot is drained.
// Path: a byte is held in the input register; the summary of a packet is
// loaded into the output register at the edge at which its last byte leaves
// the input register, and out_valid rises with that load. The capture and
// summary logic between these two registers is combinational.
// Stall: while a summary waits in the output register, non-final bytes keep
// flowing into the capture state; a final byte waits in the input register
// until the pending summary is taken, and in_ready drops behind it.
// Reset: clears the byte count, the captured fields and both valid flags;
// the block then expects byte zero of a new packet.
module ip_header_field_extractor_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [3:0]       version,
	output logic [7:0]       protocol,
	output logic [63:0]      src_addr_high,
	output logic [63:0]      src_addr_low,
	output logic [63:0]      dst_addr_high,
	output logic [63:0]      dst_addr_low,
	output logic [15:0]      src_port,
	output logic [15:0]      dst_port,
	output logic [6:0]       payload_offset,
	output logic [15:0]      payload_length
);
	import iphfe_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic          adv;

	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	parse_result_t result_q;
	logic          out_valid_q;

	// input register moves on unless a final byte meets a full output slot that out_ready does not drain
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// field capture and summary
	iphfe_parse u_parse (
		.cur       (state_q),
		.data_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// capture state, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = result_q.status;
	assign version        = result_q.version;
	assign protocol       = result_q.protocol;
	assign src_addr_high  = result_q.src_addr_high;
	assign src_addr_low   = result_q.src_addr_low;
	assign dst_addr_high  = result_q.dst_addr_high;
	assign dst_addr_low   = result_q.dst_addr_low;
	assign src_port       = result_q.src_port;
	assign dst_port       = result_q.dst_port;
	assign payload_offset = result_q.payload_offset;
	assign payload_length = result_q.payload_length;

endmodule
`default_nettype wire
